@@ hw/rtl/tgc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

  localparam int COORD_W            = 12;
  localparam int CFG_W              = 25;
  localparam int DIST_W             = 25;
  localparam int FRAC_W             = 16;
  localparam int POWER_W            = FRAC_W + 1;
  localparam int CFG_INDEX_W        = 2;
  localparam int RING_DEPTH_DEFAULT = 8;
  localparam int DIV_STEPS          = POWER_W;
  localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);

  localparam logic             FRAME_MODE_RESET    = 1'b0;
  localparam logic [CFG_W-1:0] TAP_RADIUS_SQ_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] FLICK_MIN_SQ_RESET  = CFG_W'(100);
  localparam logic [CFG_W-1:0] FLICK_SPAN_SQ_RESET = CFG_W'(19600);

  typedef enum logic [2:0] {
    GESTURE_IDLE       = 3'd0,
    GESTURE_DRAG_START = 3'd1,
    GESTURE_DRAGGING   = 3'd2,
    GESTURE_FLICK      = 3'd3,
    GESTURE_TAP        = 3'd4
  } gesture_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_MODE    = 2'd0,
    CFG_TAP_RADIUS_SQ = 2'd1,
    CFG_FLICK_MIN_SQ  = 2'd2,
    CFG_FLICK_SPAN_SQ = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic               touch_pressed;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
  } tgc_in_t;

  typedef struct packed {
    gesture_t           gesture;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [POWER_W-1:0] flick_power;
  } tgc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_UPDATE,
    S_FLICK_DIST,
    S_FLICK_CHECK,
    S_DIVIDE,
    S_FLICK_COMMIT,
    S_OUTPUT
  } tgc_state_t;

  typedef enum logic [1:0] {
    DIST_IN_START,
    DIST_END_START,
    DIST_RING
  } dist_src_t;

  typedef enum logic [2:0] {
    COMMIT_NONE,
    COMMIT_PRESS,
    COMMIT_HELD,
    COMMIT_TAP,
    COMMIT_NO_FLICK,
    COMMIT_FLICK,
    COMMIT_IDLE
  } commit_t;

  typedef struct packed {
    logic      load_in;
    logic      dist_en;
    dist_src_t dist_src;
    logic      read_newest;
    logic      read_oldest;
    logic      div_start;
    logic      div_step;
    commit_t   commit;
    logic      out_load;
  } tgc_cmd_t;

  typedef struct packed {
    logic pressed;
    logic was_pressed;
    logic is_tap;
    logic ring_empty;
    logic flick_hit;
    logic div_done;
  } tgc_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tgc_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         step,
  input  wire logic [tgc_pkg::CFG_W-1:0]    excess,
  input  wire logic [tgc_pkg::CFG_W-1:0]    span,
  output logic      [tgc_pkg::POWER_W-1:0]  quotient,
  output logic                              done
);
  import tgc_pkg::*;

  logic [CFG_W:0]       rem;
  logic [POWER_W-1:0]   quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CFG_W:0]       span_ext;
  logic [CFG_W:0]       rem_sub;
  logic                 ge;
  logic [CFG_W-1:0]     rem_keep;
  logic [CFG_W-1:0]     excess_clamped;

  // The remainder stays below the divisor, so one compare and subtract per bit suffices.
  always_comb begin
    span_ext       = {1'b0, span};
    ge             = (rem >= span_ext);
    rem_sub        = rem - span_ext;
    rem_keep       = ge ? rem_sub[CFG_W-1:0] : rem[CFG_W-1:0];
    excess_clamped = (excess > span) ? span : excess;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, excess_clamped};
      quot <= '0;
    end else if (step) begin
      rem  <= {rem_keep, 1'b0};
      quot <= {quot[POWER_W-2:0], ge};
    end
  end

  assign quotient = quot;
  assign done     = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

@@ hw/rtl/tgc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgc_datapath #(
  parameter int RING_DEPTH = tgc_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tgc_pkg::tgc_in_t                in_data,
  input  wire logic                            cfg_we,
  input  wire logic [tgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tgc_pkg::CFG_W-1:0]       cfg_data,
  input  wire tgc_pkg::tgc_cmd_t               cmd,
  output tgc_pkg::tgc_status_t                 status,
  output tgc_pkg::tgc_out_t                    out_data
);
  import tgc_pkg::*;

  localparam int               IDX_W    = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic               in_pressed;
  point_t             in_point;
  logic               was_pressed;
  gesture_t           gesture;
  point_t             start_point;
  point_t             end_point;
  logic               moved;
  logic               parity;
  logic               frame_mode;
  logic [CFG_W-1:0]   tap_radius_sq;
  logic [CFG_W-1:0]   flick_min_sq;
  logic [CFG_W-1:0]   flick_span_sq;
  logic [IDX_W-1:0]   ring_oldest;
  logic [IDX_W-1:0]   ring_next;
  logic               ring_wrapped;
  point_t             point_ring [RING_DEPTH];
  point_t             rd_data;
  point_t             newest_point;
  logic [DIST_W-1:0]  dist_sq;
  logic [POWER_W-1:0] power_hold;
  tgc_out_t           out_reg;

  point_t             pa;
  point_t             pb;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [2*COORD_W-1:0] sq_x;
  logic [2*COORD_W-1:0] sq_y;
  logic [DIST_W-1:0]  dist_next;

  logic [IDX_W:0]     next_inc;
  logic               wrap_now;
  logic [IDX_W-1:0]   oldest_inc;
  logic [IDX_W-1:0]   newest_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               ring_we;

  logic [CFG_W-1:0]   excess;
  logic [CFG_W-1:0]   span_eff;
  logic [POWER_W-1:0] quotient;
  logic               div_done;

  always_comb begin
    unique case (cmd.dist_src)
      DIST_IN_START: begin
        pa = in_point;
        pb = start_point;
      end
      DIST_RING: begin
        pa = newest_point;
        pb = rd_data;
      end
      default: begin
        pa = end_point;
        pb = start_point;
      end
    endcase
    dx        = (pa.x > pb.x) ? pa.x - pb.x : pb.x - pa.x;
    dy        = (pa.y > pb.y) ? pa.y - pb.y : pb.y - pa.y;
    sq_x      = dx * dx;
    sq_y      = dy * dy;
    dist_next = {1'b0, sq_x} + {1'b0, sq_y};
  end

  always_comb begin
    next_inc   = {1'b0, ring_next} + 1'b1;
    wrap_now   = (next_inc == (IDX_W + 1)'(RING_DEPTH));
    oldest_inc = (ring_oldest == LAST_IDX) ? '0 : ring_oldest + 1'b1;
    newest_idx = (ring_next == '0) ? LAST_IDX : ring_next - 1'b1;
    rd_addr    = cmd.read_oldest ? ring_oldest : newest_idx;
    rd_en      = cmd.read_oldest | cmd.read_newest;
    ring_we    = (cmd.commit == COMMIT_HELD) && !parity;
    excess     = dist_sq - flick_min_sq;
    span_eff   = (flick_span_sq == '0) ? CFG_W'(1) : flick_span_sq;
  end

  tgc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .excess   (excess),
    .span     (span_eff),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (ring_we) begin
      point_ring[ring_next] <= in_point;
    end
    if (rd_en) begin
      rd_data <= point_ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_pressed <= in_data.touch_pressed;
      in_point   <= '{y: in_data.touch_y, x: in_data.touch_x};
    end
    if (cmd.dist_en) begin
      dist_sq <= dist_next;
    end
    if (cmd.read_oldest) begin
      newest_point <= rd_data;
    end
    if (cmd.out_load) begin
      out_reg.gesture     <= gesture;
      out_reg.start_x     <= start_point.x;
      out_reg.start_y     <= start_point.y;
      out_reg.end_x       <= end_point.x;
      out_reg.end_y       <= end_point.y;
      out_reg.flick_power <= power_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode    <= FRAME_MODE_RESET;
      tap_radius_sq <= TAP_RADIUS_SQ_RESET;
      flick_min_sq  <= FLICK_MIN_SQ_RESET;
      flick_span_sq <= FLICK_SPAN_SQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_MODE:    frame_mode    <= cfg_data[0];
        CFG_TAP_RADIUS_SQ: tap_radius_sq <= cfg_data;
        CFG_FLICK_MIN_SQ:  flick_min_sq  <= cfg_data;
        CFG_FLICK_SPAN_SQ: flick_span_sq <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed  <= 1'b0;
      gesture      <= GESTURE_IDLE;
      start_point  <= '0;
      end_point    <= '0;
      moved        <= 1'b0;
      parity       <= 1'b0;
      ring_oldest  <= '0;
      ring_next    <= '0;
      ring_wrapped <= 1'b0;
      power_hold   <= '0;
    end else begin
      if (cmd.commit != COMMIT_NONE) begin
        was_pressed <= in_pressed;
      end
      unique case (cmd.commit)
        COMMIT_NONE: begin
        end
        COMMIT_PRESS: begin
          start_point <= in_point;
          gesture     <= GESTURE_DRAG_START;
          moved       <= 1'b0;
        end
        COMMIT_HELD: begin
          end_point <= in_point;
          gesture   <= GESTURE_DRAGGING;
          if (dist_sq >= tap_radius_sq) begin
            moved <= 1'b1;
          end
          if (!parity) begin
            ring_next <= wrap_now ? '0 : next_inc[IDX_W-1:0];
            if (wrap_now) begin
              ring_wrapped <= 1'b1;
            end
            if (ring_wrapped || wrap_now) begin
              ring_oldest <= oldest_inc;
            end
          end
          if (!frame_mode) begin
            parity <= ~parity;
          end
        end
        COMMIT_TAP: begin
          gesture <= GESTURE_TAP;
        end
        COMMIT_NO_FLICK: begin
          gesture <= GESTURE_IDLE;
        end
        COMMIT_FLICK: begin
          gesture    <= GESTURE_FLICK;
          power_hold <= quotient;
        end
        COMMIT_IDLE: begin
          gesture      <= GESTURE_IDLE;
          power_hold   <= '0;
          parity       <= 1'b0;
          ring_oldest  <= '0;
          ring_next    <= '0;
          ring_wrapped <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.pressed     = in_pressed;
    status.was_pressed = was_pressed;
    status.is_tap      = !moved && (dist_sq < tap_radius_sq);
    status.ring_empty  = (ring_oldest == ring_next);
    status.flick_hit   = (dist_sq > flick_min_sq);
    status.div_done    = div_done;
  end

  assign out_data = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tgc_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgc_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire tgc_pkg::tgc_status_t status,
  output tgc_pkg::tgc_cmd_t         cmd
);
  import tgc_pkg::*;

  tgc_state_t state;
  tgc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.dist_src = DIST_END_START;
    cmd.commit   = COMMIT_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DIST;
        end
      end
      S_DIST: begin
        cmd.dist_en     = 1'b1;
        cmd.dist_src    = status.pressed ? DIST_IN_START : DIST_END_START;
        cmd.read_newest = 1'b1;
        state_next      = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_OUTPUT;
        priority if (status.pressed && !status.was_pressed) begin
          cmd.commit = COMMIT_PRESS;
        end else if (status.pressed) begin
          cmd.commit = COMMIT_HELD;
        end else if (!status.was_pressed) begin
          cmd.commit = COMMIT_IDLE;
        end else if (status.is_tap) begin
          cmd.commit = COMMIT_TAP;
        end else if (status.ring_empty) begin
          cmd.commit = COMMIT_NO_FLICK;
        end else begin
          cmd.read_oldest = 1'b1;
          state_next      = S_FLICK_DIST;
        end
      end
      S_FLICK_DIST: begin
        cmd.dist_en  = 1'b1;
        cmd.dist_src = DIST_RING;
        state_next   = S_FLICK_CHECK;
      end
      S_FLICK_CHECK: begin
        if (status.flick_hit) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVIDE;
        end else begin
          cmd.commit = COMMIT_NO_FLICK;
          state_next = S_OUTPUT;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_FLICK_COMMIT;
        end
      end
      S_FLICK_COMMIT: begin
        cmd.commit = COMMIT_FLICK;
        state_next = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/touch_gesture_classifier.sv @@
// Touch gesture classifier: one touch sample per display frame in, one gesture result out.
// The input channel carries touch_pressed, touch_x and touch_y; a transaction completes
// when in_valid is high and in_stall is low. The output channel carries the gesture code
// (idle, drag start, dragging, flick, tap), the start and end points and the flick power
// in Q1.16, under out_valid and out_stall. The configuration port writes frame_mode,
// tap_radius_sq, flick_min_sq and flick_span_sq by index; the user is to write them only
// while the block is idle, which the block itself does not enforce. Samples are processed
// one at a time. A press, hold, tap, idle frame or a release with an empty point ring
// passes through the distance step and the update to the output register. A release that
// compares the oldest and newest logged points but finds no flick also reads the ring,
// computes that distance and checks it against the flick minimum. A release that ends in a
// flick also runs a restoring divider at one quotient bit per cycle, then commits.
// Synchronous reset returns state and configuration to their defaults and the tracker to idle.
// The point ring needs no clearing pass; its pointers are cleared instead.
// When the receiver stalls, the result register holds its transaction. The block still
// takes the next sample and processes it, then waits until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier #(
  parameter int RING_DEPTH = tgc_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire tgc_pkg::tgc_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tgc_pkg::tgc_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tgc_pkg::CFG_W-1:0]       cfg_data
);
  import tgc_pkg::*;

  tgc_cmd_t    cmd;
  tgc_status_t status;

  tgc_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tgc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted sample did not make the block busy");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("result register loaded while a stalled transaction is pending");

  a_flick_after_divide: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit == COMMIT_FLICK) |-> $past(status.div_done))
    else $error("flick committed before the divider finished");

  a_divider_only_when_stepping: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> cmd.div_step)
    else $error("divider at its last step while the controller is not dividing");
`endif

endmodule

`default_nettype wire
